// ----- hw/rtl/spt_pkg.sv -----
// Shared types and constants for the snapshot pin table.
// Used by spt_cell and the snapshot_pin_table top level.
`timescale 1ns / 1ps

package spt_pkg;

  // Field widths
  localparam int unsigned ID_W    = 64;
  localparam int unsigned GEN_W   = 32;
  localparam int unsigned VER_W   = 64;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CFG_W   = 32;

  // Default number of table entries
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  // Reset value of the active snapshot limit register
  localparam logic [LIMIT_W-1:0] MAX_ACTIVE_RST = LIMIT_W'(16);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_ACTIVE = 1'b0,
    CFG_CUR_GEN    = 1'b1
  } cfg_idx_e;

  // Request opcode on the input channel
  typedef enum logic [0:0] {
    REQ_CREATE  = 1'b0,
    REQ_RELEASE = 1'b1
  } req_op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_MANY  = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  // Operation carried by a token along the cell chain
  typedef enum logic [1:0] {
    OP_NOP     = 2'd0,
    OP_CREATE  = 2'd1,
    OP_RELEASE = 2'd2
  } cell_op_e;

  // Token handed from cell to cell
  typedef struct packed {
    logic             vld;
    cell_op_e         op;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    logic [VER_W-1:0] ver;
    logic             done;     // create placed / release matched
    logic [VER_W-1:0] min_ver;  // running minimum of live versions
  } tok_t;

  // Finished result
  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    new_id;
    logic [GEN_W-1:0]   new_gen;
    logic [VER_W-1:0]   min_ver;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

// ----- hw/rtl/spt_cell.sv -----
// One table entry of the snapshot pin table chain.
// Depends on spt_pkg for the token type and field widths.
`timescale 1ns / 1ps

module spt_cell import spt_pkg::*; #(
  parameter int unsigned CntW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tok_t            tok_i,
  input  logic [CntW-1:0] cnt_i,
  output tok_t            tok_o,
  output logic [CntW-1:0] cnt_o
);

  logic             valid_q, valid_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic [VER_W-1:0] ver_q, ver_d;
  tok_t             tok_q, tok_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             hit;

  // Update the entry from the passing token, then fold it into min and count
  always_comb begin
    hit     = valid_q && (id_q == tok_i.id);
    valid_d = valid_q;
    id_d    = id_q;
    gen_d   = gen_q;
    ver_d   = ver_q;
    tok_d   = tok_i;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_CREATE: begin
          if (hit && tok_i.done) begin
            // New id already placed upstream: drop the stale duplicate
            valid_d = 1'b0;
          end else if (hit || (!valid_q && !tok_i.done)) begin
            valid_d    = 1'b1;
            id_d       = tok_i.id;
            gen_d      = tok_i.gen;
            ver_d      = tok_i.ver;
            tok_d.done = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (hit && (gen_q == tok_i.gen)) begin
            valid_d    = 1'b0;
            tok_d.done = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (valid_d && (ver_d < tok_i.min_ver)) begin
      tok_d.min_ver = ver_d;
    end
    cnt_d = cnt_i + CntW'(valid_d);
  end

  // Hold control state and the passing token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    gen_q <= gen_d;
    ver_q <= ver_d;
    cnt_q <= cnt_d;
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

// ----- hw/rtl/snapshot_pin_table.sv -----
// Snapshot pin table: a chain of TableEntries cells, one entry per cell.
// A request is held in the issue register, then in each cell in turn, then in
// the result register. The request token walks the chain one cell per cycle, and
// the next request is stalled until the last result is delivered.
// Reset clears every entry valid bit, the id counter, the active count and
// the registers (limit 16, generation 0); entry payloads are not cleared.
`timescale 1ns / 1ps

module snapshot_pin_table import spt_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [VER_W-1:0]   current_version_i,
  input  logic [ID_W-1:0]    release_id_i,
  input  logic [GEN_W-1:0]   release_generation_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [ID_W-1:0]    new_id_o,
  output logic [GEN_W-1:0]   new_generation_o,
  output logic [VER_W-1:0]   least_version_o,
  output logic [COUNT_W-1:0] active_count_o
);

  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned CmpW = (CntW > LIMIT_W) ? CntW : LIMIT_W;

  logic [LIMIT_W-1:0] max_active_q;
  logic [GEN_W-1:0]   cur_gen_q;
  logic [ID_W-1:0]    next_id_q, next_id_d;
  logic [CntW-1:0]    count_q;
  logic               busy_q, busy_d;
  tok_t               issue_q, issue_d;
  logic               out_vld_q, out_vld_d;
  res_t               out_q;
  logic               hold_vld_q, hold_vld_d;
  res_t               hold_q;

  logic               in_acc;
  logic [CmpW-1:0]    limit;
  logic               room;
  logic               out_free;
  logic               deliver;
  res_t               res;

  tok_t               chain_tok [TableEntries+1];
  logic [CntW-1:0]    chain_cnt [TableEntries+1];
  logic [TableEntries:0] chain_vld;

  // Clamp the limit to the table size and check for a free place
  always_comb begin
    limit = (CmpW'(max_active_q) > CmpW'(TableEntries)) ? CmpW'(TableEntries)
                                                        : CmpW'(max_active_q);
    room  = CmpW'(count_q) < limit;
  end

  assign in_acc     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  // Build the request token
  always_comb begin
    issue_d         = issue_q;
    issue_d.vld     = in_acc;
    issue_d.done    = 1'b0;
    issue_d.min_ver = '1;
    issue_d.ver     = current_version_i;
    next_id_d       = next_id_q;
    if (opcode_i == REQ_RELEASE) begin
      issue_d.op  = OP_RELEASE;
      issue_d.id  = release_id_i;
      issue_d.gen = release_generation_i;
    end else begin
      issue_d.op  = room ? OP_CREATE : OP_NOP;
      issue_d.id  = next_id_q;
      issue_d.gen = cur_gen_q;
      if (in_acc && room) begin
        next_id_d = next_id_q + ID_W'(1);
      end
    end
  end

  // Chain of table cells
  assign chain_tok[0] = issue_q;
  assign chain_cnt[0] = '0;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    spt_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain_tok[g]),
      .cnt_i  (chain_cnt[g]),
      .tok_o  (chain_tok[g+1]),
      .cnt_o  (chain_cnt[g+1])
    );
  end

  for (genvar g = 0; g <= TableEntries; g++) begin : g_vld
    assign chain_vld[g] = chain_tok[g].vld;
  end

  // Form the result from the token leaving the last cell
  always_comb begin
    res.min_ver = chain_tok[TableEntries].min_ver;
    res.count   = COUNT_W'(chain_cnt[TableEntries]);
    res.new_id  = '0;
    res.new_gen = '0;
    case (chain_tok[TableEntries].op)
      OP_CREATE: begin
        res.status  = STAT_OK;
        res.new_id  = chain_tok[TableEntries].id;
        res.new_gen = chain_tok[TableEntries].gen;
      end
      OP_RELEASE: begin
        res.status = chain_tok[TableEntries].done ? STAT_OK : STAT_NOT_FOUND;
      end
      default: begin
        res.status = STAT_TOO_MANY;
      end
    endcase
  end

  // Output register with a one-deep hold stage behind it
  assign out_free = !out_vld_q || !out_stall_i;
  assign deliver  = out_free && (hold_vld_q || chain_vld[TableEntries]);

  always_comb begin
    hold_vld_d = hold_vld_q;
    out_vld_d  = out_vld_q;
    if (out_free) begin
      out_vld_d  = hold_vld_q || chain_vld[TableEntries];
      hold_vld_d = 1'b0;
    end else if (chain_vld[TableEntries]) begin
      hold_vld_d = 1'b1;
    end
    busy_d = busy_q;
    if (in_acc) begin
      busy_d = 1'b1;
    end else if (deliver) begin
      busy_d = 1'b0;
    end
  end

  // Hold control state and the issued request token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_active_q <= MAX_ACTIVE_RST;
      cur_gen_q    <= '0;
      next_id_q    <= '0;
      count_q      <= '0;
      busy_q       <= 1'b0;
      issue_q      <= '0;
      out_vld_q    <= 1'b0;
      hold_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_ACTIVE: max_active_q <= cfg_wdata_i[LIMIT_W-1:0];
          CFG_CUR_GEN:    cur_gen_q    <= cfg_wdata_i[GEN_W-1:0];
          default: ;
        endcase
      end
      next_id_q  <= next_id_d;
      busy_q     <= busy_d;
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
      if (in_acc) begin
        issue_q <= issue_d;
      end else begin
        issue_q.vld <= 1'b0;
      end
      if (chain_vld[TableEntries]) begin
        count_q <= chain_cnt[TableEntries];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= hold_vld_q ? hold_q : res;
    end else if (chain_vld[TableEntries]) begin
      hold_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_q.status;
  assign new_id_o         = out_q.new_id;
  assign new_generation_o = out_q.new_gen;
  assign least_version_o  = out_q.min_ver;
  assign active_count_o   = out_q.count;

  // At most one request token travels the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one request in the cell chain");

  // A token in the chain implies the block is busy
  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_vld != '0) |-> busy_q)
    else $error("request in chain while not busy");

  // The hold stage fills only behind a full output register
  a_hold_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> out_vld_q)
    else $error("hold stage valid with empty output register");

  // The active count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(TableEntries))
    else $error("active count above table size");

endmodule
